// ----- design/vec3_pkg.sv -----
package vec3_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int PROD_W   = 2 * WORD_BITS;
    localparam int SUM_W    = PROD_W + 2;
    localparam int RAD_W    = PROD_W;
    localparam int SQ_STEPS = WORD_BITS;
    localparam int ROOT_W   = WORD_BITS;
    localparam int SQREM_W  = WORD_BITS + 3;
    localparam int LEN_W    = WORD_BITS + 1;
    localparam int Q_W      = FRAC_BITS + 2;
    localparam int NUM_W    = WORD_BITS + FRAC_BITS;
    localparam int CMP_W    = (Q_W + 1 > LEN_W) ? Q_W + 1 : LEN_W;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_SCALE = 3'd2;
    localparam logic [2:0] MODE_DOT   = 3'd3;
    localparam logic [2:0] MODE_CROSS = 3'd4;
    localparam logic [2:0] MODE_LEN   = 3'd5;
    localparam logic [2:0] MODE_NORM  = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word MINNEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [2:0] mode;
        t_word      ax;
        t_word      ay;
        t_word      az;
        t_word      bx;
        t_word      by;
        t_word      bz;
        t_word      scale_factor;
    } t_req;

    typedef struct packed {
        t_word      rx;
        t_word      ry;
        t_word      rz;
        t_word      rscalar;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [2:0] mode;
        t_word      ax;
        t_word      ay;
        t_word      az;
        t_word      rx;
        t_word      ry;
        t_word      rz;
        t_word      rscalar;
        logic       sat;
        logic       zlen;
    } t_carry;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [ROOT_W-1:0]  root;
        logic [SQREM_W-1:0] rem;
    } t_sq;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   nbits;
    } t_dlane;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_dlane [2:0]     lane;
    } t_div;

    typedef struct packed {
        t_word val;
        logic  sat;
    } t_rnd;

endpackage

// ----- design/vec3_front.sv -----
module vec3_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  vec3_pkg::t_req              i_req,
    output logic                        o_valid,
    output vec3_pkg::t_carry            o_carry,
    output logic [vec3_pkg::RAD_W-1:0]  o_rad
);

    function automatic vec3_pkg::t_rnd add_sat(input vec3_pkg::t_word a,
                                               input vec3_pkg::t_word b,
                                               input logic sub);
        logic signed [vec3_pkg::WORD_BITS:0] e;
        vec3_pkg::t_rnd r;
        if (sub) begin
            e = {a[vec3_pkg::WORD_BITS-1], a} - {b[vec3_pkg::WORD_BITS-1], b};
        end else begin
            e = {a[vec3_pkg::WORD_BITS-1], a} + {b[vec3_pkg::WORD_BITS-1], b};
        end
        r.sat = e[vec3_pkg::WORD_BITS] != e[vec3_pkg::WORD_BITS-1];
        if (r.sat) begin
            r.val = e[vec3_pkg::WORD_BITS] ? vec3_pkg::MINNEG : vec3_pkg::MAXPOS;
        end else begin
            r.val = e[vec3_pkg::WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic vec3_pkg::t_rnd fx_round(input logic signed [vec3_pkg::SUM_W-1:0] v);
        logic signed [vec3_pkg::SUM_W-1:0] t;
        logic signed [vec3_pkg::SUM_W-1:0] hi;
        logic signed [vec3_pkg::SUM_W-1:0] lo;
        vec3_pkg::t_rnd r;
        hi = vec3_pkg::SUM_W'(vec3_pkg::MAXPOS);
        lo = vec3_pkg::SUM_W'(vec3_pkg::MINNEG);
        t  = v + {{(vec3_pkg::SUM_W-vec3_pkg::FRAC_BITS){1'b0}}, 1'b1,
                  {(vec3_pkg::FRAC_BITS-1){1'b0}}};
        t  = t >>> vec3_pkg::FRAC_BITS;
        if (t > hi) begin
            r.val = vec3_pkg::MAXPOS;
            r.sat = 1'b1;
        end else if (t < lo) begin
            r.val = vec3_pkg::MINNEG;
            r.sat = 1'b1;
        end else begin
            r.val = t[vec3_pkg::WORD_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // stage 1: products and add / subtract
    vec3_pkg::t_word                       w_ma [6];
    vec3_pkg::t_word                       w_mb [6];
    logic signed [vec3_pkg::PROD_W-1:0]    w_p  [6];
    vec3_pkg::t_rnd                        w_as [3];

    logic                                  r1_v;
    vec3_pkg::t_req                        r1_req;
    logic signed [vec3_pkg::PROD_W-1:0]    r1_p [6];
    vec3_pkg::t_rnd                        r1_as [3];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_ma[k] = '0;
            w_mb[k] = '0;
        end
        unique case (i_req.mode) inside
            vec3_pkg::MODE_SCALE: begin
                w_ma[0] = i_req.ax; w_mb[0] = i_req.scale_factor;
                w_ma[1] = i_req.ay; w_mb[1] = i_req.scale_factor;
                w_ma[2] = i_req.az; w_mb[2] = i_req.scale_factor;
            end
            vec3_pkg::MODE_CROSS: begin
                w_ma[0] = i_req.ay; w_mb[0] = i_req.bz;
                w_ma[1] = i_req.az; w_mb[1] = i_req.bx;
                w_ma[2] = i_req.ax; w_mb[2] = i_req.by;
                w_ma[3] = i_req.az; w_mb[3] = i_req.by;
                w_ma[4] = i_req.ax; w_mb[4] = i_req.bz;
                w_ma[5] = i_req.ay; w_mb[5] = i_req.bx;
            end
            vec3_pkg::MODE_LEN, vec3_pkg::MODE_NORM: begin
                w_ma[0] = i_req.ax; w_mb[0] = i_req.ax;
                w_ma[1] = i_req.ay; w_mb[1] = i_req.ay;
                w_ma[2] = i_req.az; w_mb[2] = i_req.az;
            end
            default: begin
                w_ma[0] = i_req.ax; w_mb[0] = i_req.bx;
                w_ma[1] = i_req.ay; w_mb[1] = i_req.by;
                w_ma[2] = i_req.az; w_mb[2] = i_req.bz;
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            w_p[k] = w_ma[k] * w_mb[k];
        end
        w_as[0] = add_sat(i_req.ax, i_req.bx, i_req.mode == vec3_pkg::MODE_SUB);
        w_as[1] = add_sat(i_req.ay, i_req.by, i_req.mode == vec3_pkg::MODE_SUB);
        w_as[2] = add_sat(i_req.az, i_req.bz, i_req.mode == vec3_pkg::MODE_SUB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_req <= i_req;
            r1_p   <= w_p;
            r1_as  <= w_as;
        end
    end

    // stage 2: sums and differences of products
    logic                                  r2_v;
    vec3_pkg::t_req                        r2_req;
    logic signed [vec3_pkg::SUM_W-1:0]     r2_s [4];
    vec3_pkg::t_rnd                        r2_as [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_req  <= r1_req;
            r2_as   <= r1_as;
            r2_s[0] <= vec3_pkg::SUM_W'(r1_p[0]) - vec3_pkg::SUM_W'(r1_p[3]);
            r2_s[1] <= vec3_pkg::SUM_W'(r1_p[1]) - vec3_pkg::SUM_W'(r1_p[4]);
            r2_s[2] <= vec3_pkg::SUM_W'(r1_p[2]) - vec3_pkg::SUM_W'(r1_p[5]);
            r2_s[3] <= vec3_pkg::SUM_W'(r1_p[0]) + vec3_pkg::SUM_W'(r1_p[1])
                     + vec3_pkg::SUM_W'(r1_p[2]);
        end
    end

    // stage 3: rounding, saturation and result selection
    vec3_pkg::t_rnd   w_r [4];
    vec3_pkg::t_carry n_carry;
    logic             r3_v;
    vec3_pkg::t_carry r3_carry;
    logic [vec3_pkg::RAD_W-1:0] r3_rad;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_r[k] = fx_round(r2_s[k]);
        end
        n_carry      = '0;
        n_carry.mode = r2_req.mode;
        n_carry.ax   = r2_req.ax;
        n_carry.ay   = r2_req.ay;
        n_carry.az   = r2_req.az;
        unique case (r2_req.mode) inside
            vec3_pkg::MODE_ADD, vec3_pkg::MODE_SUB: begin
                n_carry.rx  = r2_as[0].val;
                n_carry.ry  = r2_as[1].val;
                n_carry.rz  = r2_as[2].val;
                n_carry.sat = r2_as[0].sat | r2_as[1].sat | r2_as[2].sat;
            end
            vec3_pkg::MODE_SCALE, vec3_pkg::MODE_CROSS: begin
                n_carry.rx  = w_r[0].val;
                n_carry.ry  = w_r[1].val;
                n_carry.rz  = w_r[2].val;
                n_carry.sat = w_r[0].sat | w_r[1].sat | w_r[2].sat;
            end
            vec3_pkg::MODE_DOT: begin
                n_carry.rscalar = w_r[3].val;
                n_carry.sat     = w_r[3].sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_carry <= n_carry;
            r3_rad   <= r2_s[3][vec3_pkg::RAD_W-1:0];
        end
    end

    assign o_valid = r3_v;
    assign o_carry = r3_carry;
    assign o_rad   = r3_rad;

endmodule

// ----- design/vec3_sqrt_cell.sv -----
module vec3_sqrt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vec3_pkg::t_carry i_carry,
    input  vec3_pkg::t_sq    i_sq,
    output logic             o_valid,
    output vec3_pkg::t_carry o_carry,
    output vec3_pkg::t_sq    o_sq
);

    logic [vec3_pkg::SQREM_W-1:0] w_rem;
    logic [vec3_pkg::SQREM_W-1:0] w_trial;
    vec3_pkg::t_sq                n_sq;
    logic                         r_valid;
    vec3_pkg::t_carry             r_carry;
    vec3_pkg::t_sq                r_sq;

    // one result bit per cell, restoring form
    always_comb begin
        w_rem   = {i_sq.rem[vec3_pkg::SQREM_W-3:0],
                   i_sq.rad[vec3_pkg::RAD_W-1:vec3_pkg::RAD_W-2]};
        w_trial = vec3_pkg::SQREM_W'({i_sq.root, 2'b01});
        n_sq.rad = {i_sq.rad[vec3_pkg::RAD_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_sq.rem  = w_rem - w_trial;
            n_sq.root = {i_sq.root[vec3_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_sq.rem  = w_rem;
            n_sq.root = {i_sq.root[vec3_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry <= i_carry;
            r_sq    <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_sq    = r_sq;

endmodule

// ----- design/vec3_div_cell.sv -----
module vec3_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vec3_pkg::t_carry i_carry,
    input  vec3_pkg::t_div   i_div,
    output logic             o_valid,
    output vec3_pkg::t_carry o_carry,
    output vec3_pkg::t_div   o_div
);

    logic [vec3_pkg::LEN_W:0] w_t [3];
    vec3_pkg::t_div           n_div;
    logic                     r_valid;
    vec3_pkg::t_carry         r_carry;
    vec3_pkg::t_div           r_div;

    // one quotient bit per lane per cell
    always_comb begin
        n_div.len = i_div.len;
        for (int k = 0; k < 3; k++) begin
            w_t[k] = {i_div.lane[k].rem, i_div.lane[k].nbits[vec3_pkg::Q_W-1]};
            n_div.lane[k].nbits = {i_div.lane[k].nbits[vec3_pkg::Q_W-2:0], 1'b0};
            if (w_t[k] >= {1'b0, i_div.len}) begin
                n_div.lane[k].rem = vec3_pkg::LEN_W'(w_t[k] - {1'b0, i_div.len});
                n_div.lane[k].q   = {i_div.lane[k].q[vec3_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_div.lane[k].rem = w_t[k][vec3_pkg::LEN_W-1:0];
                n_div.lane[k].q   = {i_div.lane[k].q[vec3_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry <= i_carry;
            r_div   <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_div   = r_div;

endmodule

// ----- design/vector3_alu.sv -----
// channel   direction  handshake                   payload
// request   in         i_req_valid / o_req_stall   i_req (t_req)
// result    out        o_rsp_valid / i_rsp_stall   o_rsp (t_rsp)
//
// one request per cycle while o_req_stall is low; a result passes, in order, through the
// input register, three product / rounding stages, 32 square root cells,
// a length stage, 18 division cells and the output register.
// synchronous active-low reset clears the valid bits only.
// a stalled result is held; one more result goes to a skid register, after which
// o_req_stall rises and the whole pipe holds until the skid drains.
module vector3_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  vec3_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output vec3_pkg::t_rsp o_rsp
);

    logic w_en;

    // input register
    logic           r_v0;
    vec3_pkg::t_req r_req0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req0 <= i_req;
        end
    end

    // products, sums, rounding
    logic                       w_f_v;
    vec3_pkg::t_carry           w_f_c;
    logic [vec3_pkg::RAD_W-1:0] w_f_rad;

    vec3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v0),
        .i_req   (r_req0),
        .o_valid (w_f_v),
        .o_carry (w_f_c),
        .o_rad   (w_f_rad)
    );

    // square root row
    logic             w_sq_v [vec3_pkg::SQ_STEPS+1];
    vec3_pkg::t_carry w_sq_c [vec3_pkg::SQ_STEPS+1];
    vec3_pkg::t_sq    w_sq   [vec3_pkg::SQ_STEPS+1];

    assign w_sq_v[0]    = w_f_v;
    assign w_sq_c[0]    = w_f_c;
    assign w_sq[0].rad  = w_f_rad;
    assign w_sq[0].root = '0;
    assign w_sq[0].rem  = '0;

    for (genvar g = 0; g < vec3_pkg::SQ_STEPS; g++) begin : g_sq
        vec3_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_carry (w_sq_c[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_carry (w_sq_c[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    // length stage
    logic [vec3_pkg::LEN_W-1:0] w_len;
    logic [vec3_pkg::NUM_W-1:0] w_num [3];
    vec3_pkg::t_word            w_la  [3];
    vec3_pkg::t_carry           n_lc;
    vec3_pkg::t_div             n_ld;
    logic                       r_lv;
    vec3_pkg::t_carry           r_lc;
    vec3_pkg::t_div             r_ld;

    always_comb begin
        w_len = {1'b0, w_sq[vec3_pkg::SQ_STEPS].root}
              + vec3_pkg::LEN_W'(vec3_pkg::SQREM_W'(w_sq[vec3_pkg::SQ_STEPS].root)
                                 < w_sq[vec3_pkg::SQ_STEPS].rem);
        n_lc      = w_sq_c[vec3_pkg::SQ_STEPS];
        n_lc.zlen = w_len == '0;
        if (n_lc.mode == vec3_pkg::MODE_LEN) begin
            if (w_len > {1'b0, vec3_pkg::MAXPOS}) begin
                n_lc.rscalar = vec3_pkg::MAXPOS;
                n_lc.sat     = 1'b1;
            end else begin
                n_lc.rscalar = w_len[vec3_pkg::WORD_BITS-1:0];
            end
        end
        w_la[0]  = n_lc.ax;
        w_la[1]  = n_lc.ay;
        w_la[2]  = n_lc.az;
        n_ld.len = w_len;
        for (int k = 0; k < 3; k++) begin
            w_num[k] = {(w_la[k][vec3_pkg::WORD_BITS-1] ? -w_la[k] : w_la[k]),
                        {vec3_pkg::FRAC_BITS{1'b0}}};
            n_ld.lane[k].rem   = vec3_pkg::LEN_W'(w_num[k][vec3_pkg::NUM_W-1:vec3_pkg::Q_W]);
            n_ld.lane[k].nbits = w_num[k][vec3_pkg::Q_W-1:0];
            n_ld.lane[k].q     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (w_en) begin
            r_lv <= w_sq_v[vec3_pkg::SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lc <= n_lc;
            r_ld <= n_ld;
        end
    end

    // division row
    logic             w_dv_v [vec3_pkg::Q_W+1];
    vec3_pkg::t_carry w_dv_c [vec3_pkg::Q_W+1];
    vec3_pkg::t_div   w_dv   [vec3_pkg::Q_W+1];

    assign w_dv_v[0] = r_lv;
    assign w_dv_c[0] = r_lc;
    assign w_dv[0]   = r_ld;

    for (genvar g = 0; g < vec3_pkg::Q_W; g++) begin : g_dv
        vec3_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[g]),
            .i_carry (w_dv_c[g]),
            .i_div   (w_dv[g]),
            .o_valid (w_dv_v[g+1]),
            .o_carry (w_dv_c[g+1]),
            .o_div   (w_dv[g+1])
        );
    end

    // quotient rounding and result assembly
    vec3_pkg::t_carry           w_c;
    vec3_pkg::t_div             w_d;
    vec3_pkg::t_word            w_na  [3];
    logic [vec3_pkg::Q_W:0]     w_qr  [3];
    logic [vec3_pkg::CMP_W-1:0] w_lim [3];
    vec3_pkg::t_word            w_nv  [3];
    logic [2:0]                 w_ns;
    vec3_pkg::t_rsp             w_rsp;
    logic                       w_pv;

    always_comb begin
        w_c     = w_dv_c[vec3_pkg::Q_W];
        w_d     = w_dv[vec3_pkg::Q_W];
        w_pv    = w_dv_v[vec3_pkg::Q_W];
        w_na[0] = w_c.ax;
        w_na[1] = w_c.ay;
        w_na[2] = w_c.az;
        for (int k = 0; k < 3; k++) begin
            w_qr[k] = {1'b0, w_d.lane[k].q}
                    + (vec3_pkg::Q_W+1)'({w_d.lane[k].rem, 1'b0} >= {1'b0, w_d.len});
            w_lim[k] = vec3_pkg::CMP_W'({1'b0, vec3_pkg::MAXPOS})
                     + vec3_pkg::CMP_W'(w_na[k][vec3_pkg::WORD_BITS-1]);
            w_ns[k] = vec3_pkg::CMP_W'(w_qr[k]) > w_lim[k];
            if (w_ns[k]) begin
                w_nv[k] = w_na[k][vec3_pkg::WORD_BITS-1] ? vec3_pkg::MINNEG
                                                         : vec3_pkg::MAXPOS;
            end else if (w_na[k][vec3_pkg::WORD_BITS-1]) begin
                w_nv[k] = -vec3_pkg::WORD_BITS'(w_qr[k]);
            end else begin
                w_nv[k] = vec3_pkg::WORD_BITS'(w_qr[k]);
            end
        end
        w_rsp.rx      = w_c.rx;
        w_rsp.ry      = w_c.ry;
        w_rsp.rz      = w_c.rz;
        w_rsp.rscalar = w_c.rscalar;
        w_rsp.status  = w_c.sat ? vec3_pkg::ST_SAT : vec3_pkg::ST_OK;
        if (w_c.mode == vec3_pkg::MODE_NORM) begin
            if (w_c.zlen) begin
                w_rsp.status = vec3_pkg::ST_ZERO;
            end else begin
                w_rsp.rx     = w_nv[0];
                w_rsp.ry     = w_nv[1];
                w_rsp.rz     = w_nv[2];
                w_rsp.status = (|w_ns) ? vec3_pkg::ST_SAT : vec3_pkg::ST_OK;
            end
        end
    end

    // output register and skid
    logic           r_ov;
    vec3_pkg::t_rsp r_od;
    logic           r_sv;
    vec3_pkg::t_rsp r_sd;
    logic           w_take;

    assign w_en   = !r_sv;
    assign w_take = r_ov && !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || w_take) begin
            r_ov <= w_pv;
        end else if (w_pv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_od <= r_sd;
            end
        end else if (!r_ov || w_take) begin
            r_od <= w_rsp;
        end else begin
            r_sd <= w_rsp;
        end
    end

    assign o_req_stall = r_sv;
    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_od;

endmodule

// ----- design/vec3_chk.sv -----
module vec3_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input vec3_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input vec3_pkg::t_rsp o_rsp
);

    // result held while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped or changed under stall");

    // the request side only stalls with a result waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> o_rsp_valid)
        else $error("request stall without pending result");

    // stall only rises when the result side is blocked
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_req_stall) |-> $past(o_rsp_valid && i_rsp_stall))
        else $error("request stall raised without result stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.status == vec3_pkg::ST_OK
                     || o_rsp.status == vec3_pkg::ST_SAT
                     || o_rsp.status == vec3_pkg::ST_ZERO)
        else $error("unknown status");

    // zero-length normalize gives an all-zero result
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == vec3_pkg::ST_ZERO |->
            o_rsp.rx == '0 && o_rsp.ry == '0 && o_rsp.rz == '0 && o_rsp.rscalar == '0)
        else $error("non-zero result on zero-length normalize");

endmodule

bind vector3_alu vec3_chk u_vec3_chk (.*);
